/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL files of the project.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* rtl/core/lfupr_pkg.sv */
// ----------------------------------------------------------------------------
// LFU page replacement package
// Field widths, counter limits, the frame entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package lfupr_pkg;

   localparam int PAGE_W  = 16;
   localparam int USE_W   = 16;
   localparam int TIME_W  = 32;
   localparam int FAULT_W = 32;
   localparam int CFG_W   = 4;
   localparam int SLOT_W  = 3;

   localparam logic [CFG_W-1:0]   ACTIVE_RESET = 4'd8;
   localparam logic [USE_W-1:0]   USE_MAX      = '1;
   localparam logic [TIME_W-1:0]  TIME_MAX     = '1;
   localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

   // One frame as it is kept in the frame memory.
   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [USE_W-1:0]  use_count;
      logic [TIME_W-1:0] arrival;
   } frame_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

/* rtl/core/lfupr_if.sv */
// ----------------------------------------------------------------------------
// LFU page replacement channels
// Valid/ready channels for reference words, result words and register writes.
// ----------------------------------------------------------------------------
interface lfupr_req_if;
   logic                         valid;
   logic                         ready;
   logic [lfupr_pkg::PAGE_W-1:0] page;
   logic                         last_reference;

   modport source (output valid, output page, output last_reference, input ready);
   modport sink (input valid, input page, input last_reference, output ready);
endinterface

interface lfupr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lfupr_pkg::SLOT_W-1:0]  slot;
   logic                          evicted_valid;
   logic [lfupr_pkg::PAGE_W-1:0]  evicted_page;
   logic [lfupr_pkg::FAULT_W-1:0] faults_so_far;
   logic                          end_of_string;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_page, output faults_so_far, output end_of_string,
                   input ready);
   modport sink (input valid, input hit, input slot, input evicted_valid,
                 input evicted_page, input faults_so_far, input end_of_string,
                 output ready);
endinterface

interface lfupr_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lfupr_pkg::CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lfupr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lfupr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lfu_page_replacement_unit.sv */
// A reference word is taken in the idle state and its frames are scanned; the block takes
// no new reference word until the chosen frame has been written back in the update state.
// The single read port of the frame memory is walked one frame per cycle, then the chosen
// frame is written back, which waits while the previous result is still held.
// Reset (synchronous, active high) empties all frames, clears the reference index and
// the fault total, and sets the active frame count to 8; there is no clearing pass.
// ----------------------------------------------------------------------------
// LFU page replacement unit
// Fully associative frame set with least-frequently-used replacement and an
// earliest-arrival tie break, built around one frame scan per reference.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_page_replacement_unit #(
   parameter int FRAMES = 8
) (
   input  logic        clock,
   input  logic        reset,
   lfupr_req_if.sink   req_bus,
   lfupr_rsp_if.source rsp_bus,
   lfupr_csr_if.sink   csr_bus
);

   // Index width for a frame, and a count width that can also hold FRAMES itself.
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int KEY_W = lfupr_pkg::USE_W + lfupr_pkg::TIME_W;
   localparam int ENTRY_W = $bits(lfupr_pkg::frame_entry_type);

   // Sequencer and configuration.
   lfupr_pkg::state_type          state_ff, state_in;
   logic [lfupr_pkg::CFG_W-1:0]   active_ff, active_in;

   // The reference word being worked on, and the clamped active frame count.
   logic [lfupr_pkg::PAGE_W-1:0]  page_ff, page_in;
   logic                          last_ff, last_in;
   logic [CNT_W-1:0]              n_ff, n_in;

   // Scan pipeline: issue stage addresses the memory, check stage sees its data.
   logic [CNT_W-1:0]              issue_ff, issue_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;

   // What the scan has found so far.
   logic                          hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in;
   lfupr_pkg::frame_entry_type    hit_entry_ff, hit_entry_in;
   logic                          empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]              empty_idx_ff, empty_idx_in;
   logic                          min_found_ff, min_found_in;
   logic [IDX_W-1:0]              min_idx_ff, min_idx_in;
   logic [KEY_W-1:0]              min_key_ff, min_key_in;
   logic [lfupr_pkg::PAGE_W-1:0]  min_page_ff, min_page_in;

   // Per-string state held in flops.
   logic [FRAMES-1:0]             valid_ff, valid_in;
   logic [lfupr_pkg::TIME_W-1:0]  ref_idx_ff, ref_idx_in;
   logic [lfupr_pkg::FAULT_W-1:0] fault_ff, fault_in;

   // Output register; it lets the next reference word start while a result waits.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [lfupr_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                          rsp_evicted_ff, rsp_evicted_in;
   logic [lfupr_pkg::PAGE_W-1:0]  rsp_evicted_page_ff, rsp_evicted_page_in;
   logic [lfupr_pkg::FAULT_W-1:0] rsp_faults_ff, rsp_faults_in;
   logic                          rsp_end_ff, rsp_end_in;

   // Frame memory ports.
   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   logic [ENTRY_W-1:0]            ram_wr_data;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [ENTRY_W-1:0]            ram_rd_data;

   // Helper nets.
   logic                          req_fire;
   logic                          issuing;
   logic                          out_free;
   logic                          upd_fire;
   logic                          chk_valid;
   lfupr_pkg::frame_entry_type    rd_entry;
   lfupr_pkg::frame_entry_type    wr_entry;
   logic [IDX_W-1:0]              slot_idx;
   logic [IDX_W+lfupr_pkg::SLOT_W-1:0] slot_wide;
   logic [7:0]                    act_wide;
   logic [7:0]                    lim_wide;

   // The frame memory holds page, use count and arrival time for every frame.
   // Empty frames are tracked by the valid flops, so the memory needs no clearing.
   lfupr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign issuing   = (state_ff == lfupr_pkg::ST_SCAN) && (issue_ff < n_ff);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign upd_fire  = (state_ff == lfupr_pkg::ST_UPDATE) && out_free;
   assign rd_entry  = lfupr_pkg::frame_entry_type'(ram_rd_data);
   assign chk_valid = valid_ff[chk_idx_ff];

   // A zero count behaves as one frame, and a count above FRAMES as FRAMES.
   always_comb begin
      act_wide = 8'(active_ff);
      if (act_wide == 8'd0) begin
         lim_wide = 8'd1;
      end else if (act_wide > 8'(FRAMES)) begin
         lim_wide = 8'(FRAMES);
      end else begin
         lim_wide = act_wide;
      end
   end

   // The frame written back: a hit bumps the use count, a fault installs the page
   // with a use count of one, stamped with the current reference index.
   always_comb begin
      if (hit_found_ff) begin
         slot_idx = hit_idx_ff;
      end else if (empty_found_ff) begin
         slot_idx = empty_idx_ff;
      end else begin
         slot_idx = min_idx_ff;
      end
      wr_entry.page = page_ff;
      if (hit_found_ff) begin
         wr_entry.use_count = (hit_entry_ff.use_count == lfupr_pkg::USE_MAX) ?
                              hit_entry_ff.use_count : hit_entry_ff.use_count + 1'b1;
         wr_entry.arrival   = hit_entry_ff.arrival;
      end else begin
         wr_entry.use_count = lfupr_pkg::USE_W'(1);
         wr_entry.arrival   = ref_idx_ff;
      end
      slot_wide = (IDX_W + lfupr_pkg::SLOT_W)'(slot_idx);
   end

   assign ram_rd_en   = issuing;
   assign ram_rd_addr = issue_ff[IDX_W-1:0];
   assign ram_wr_en   = upd_fire;
   assign ram_wr_addr = slot_idx;
   assign ram_wr_data = ENTRY_W'(wr_entry);

   always_comb begin
      state_in            = state_ff;
      active_in           = active_ff;
      page_in             = page_ff;
      last_in             = last_ff;
      n_in                = n_ff;
      issue_in            = issue_ff;
      chk_vld_in          = 1'b0;
      chk_idx_in          = chk_idx_ff;
      hit_found_in        = hit_found_ff;
      hit_idx_in          = hit_idx_ff;
      hit_entry_in        = hit_entry_ff;
      empty_found_in      = empty_found_ff;
      empty_idx_in        = empty_idx_ff;
      min_found_in        = min_found_ff;
      min_idx_in          = min_idx_ff;
      min_key_in          = min_key_ff;
      min_page_in         = min_page_ff;
      valid_in            = valid_ff;
      ref_idx_in          = ref_idx_ff;
      fault_in            = fault_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in          = rsp_hit_ff;
      rsp_slot_in         = rsp_slot_ff;
      rsp_evicted_in      = rsp_evicted_ff;
      rsp_evicted_page_in = rsp_evicted_page_ff;
      rsp_faults_in       = rsp_faults_ff;
      rsp_end_in          = rsp_end_ff;

      if (csr_bus.valid && csr_bus.ready) begin
         active_in = csr_bus.data;
      end

      case (state_ff)
         lfupr_pkg::ST_IDLE: begin
            if (req_fire) begin
               page_in        = req_bus.page;
               last_in        = req_bus.last_reference;
               n_in           = CNT_W'(lim_wide);
               issue_in       = '0;
               hit_found_in   = 1'b0;
               empty_found_in = 1'b0;
               min_found_in   = 1'b0;
               state_in       = lfupr_pkg::ST_SCAN;
            end
         end

         lfupr_pkg::ST_SCAN: begin
            if (issuing) begin
               issue_in   = issue_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
            end
            // One frame is examined per cycle for a match, the first empty frame
            // and the least (use count, arrival) key. A strict compare in frame
            // order leaves ties with the lowest frame.
            if (chk_vld_ff) begin
               if (chk_valid && (rd_entry.page == page_ff) && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = chk_idx_ff;
                  hit_entry_in = rd_entry;
               end
               if (!chk_valid && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = chk_idx_ff;
               end
               if (chk_valid && (!min_found_ff ||
                   ({rd_entry.use_count, rd_entry.arrival} < min_key_ff))) begin
                  min_found_in = 1'b1;
                  min_idx_in   = chk_idx_ff;
                  min_key_in   = {rd_entry.use_count, rd_entry.arrival};
                  min_page_in  = rd_entry.page;
               end
               if (CNT_W'(chk_idx_ff) == n_ff - CNT_W'(1)) begin
                  state_in = lfupr_pkg::ST_UPDATE;
               end
            end
         end

         lfupr_pkg::ST_UPDATE: begin
            // Waits here only while the previous result is still held.
            if (out_free) begin
               if (!hit_found_ff && (fault_ff != lfupr_pkg::FAULT_MAX)) begin
                  fault_in = fault_ff + 1'b1;
               end
               valid_in[slot_idx] = 1'b1;
               if (ref_idx_ff != lfupr_pkg::TIME_MAX) begin
                  ref_idx_in = ref_idx_ff + 1'b1;
               end

               rsp_valid_in        = 1'b1;
               rsp_hit_in          = hit_found_ff;
               rsp_slot_in         = slot_wide[lfupr_pkg::SLOT_W-1:0];
               rsp_evicted_in      = !hit_found_ff && !empty_found_ff;
               rsp_evicted_page_in = (!hit_found_ff && !empty_found_ff) ?
                                     min_page_ff : '0;
               rsp_faults_in       = fault_in;
               rsp_end_in          = last_ff;

               // The end of a string starts the next one from an empty frame set.
               if (last_ff) begin
                  valid_in   = '0;
                  ref_idx_in = '0;
                  fault_in   = '0;
               end
               state_in = lfupr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lfupr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfupr_pkg::ST_IDLE;
         active_ff    <= lfupr_pkg::ACTIVE_RESET;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         ref_idx_ff   <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         ref_idx_ff   <= ref_idx_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff             <= page_in;
      last_ff             <= last_in;
      n_ff                <= n_in;
      issue_ff            <= issue_in;
      chk_idx_ff          <= chk_idx_in;
      hit_found_ff        <= hit_found_in;
      hit_idx_ff          <= hit_idx_in;
      hit_entry_ff        <= hit_entry_in;
      empty_found_ff      <= empty_found_in;
      empty_idx_ff        <= empty_idx_in;
      min_found_ff        <= min_found_in;
      min_idx_ff          <= min_idx_in;
      min_key_ff          <= min_key_in;
      min_page_ff         <= min_page_in;
      rsp_hit_ff          <= rsp_hit_in;
      rsp_slot_ff         <= rsp_slot_in;
      rsp_evicted_ff      <= rsp_evicted_in;
      rsp_evicted_page_ff <= rsp_evicted_page_in;
      rsp_faults_ff       <= rsp_faults_in;
      rsp_end_ff          <= rsp_end_in;
   end

   // New reference words are taken only between scans; configuration is always open.
   assign req_bus.ready         = (state_ff == lfupr_pkg::ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = rsp_hit_ff;
   assign rsp_bus.slot          = rsp_slot_ff;
   assign rsp_bus.evicted_valid = rsp_evicted_ff;
   assign rsp_bus.evicted_page  = rsp_evicted_page_ff;
   assign rsp_bus.faults_so_far = rsp_faults_ff;
   assign rsp_bus.end_of_string = rsp_end_ff;

   // The fault total and the frame occupancy move only when a reference completes.
   `ASSERT_NEXT(a_fault_stable, clock, reset, !upd_fire, $stable(fault_ff))
   `ASSERT_NEXT(a_valid_stable, clock, reset, !upd_fire, $stable(valid_ff))
   // A hit must land on an occupied frame, and it never evicts anything.
   `ASSERT_IMPLY(a_hit_resident, clock, reset, upd_fire && hit_found_ff, valid_ff[hit_idx_ff])
   `ASSERT_IMPLY(a_hit_no_evict, clock, reset, rsp_valid_ff, !(rsp_hit_ff && rsp_evicted_ff))

endmodule
